FILE: rtl/bkvm_pkg.sv
package bkvm_pkg;

  localparam int KIND_W   = 2;
  localparam int KEY_W    = 32;
  localparam int BC_W     = 7;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  // one key bit per remainder step over the whole key
  localparam int DIV_STEPS = KEY_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [BC_W-1:0] BC_RESET = 7'd64;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_GET    = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic rd_en;
    logic eval;
    logic out_load;
    logic clr_step;
  } bkvm_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } bkvm_stat_t;

endpackage

FILE: rtl/bkvm_datapath.sv
module bkvm_datapath #(
  parameter int MAX_BUCKETS = 64,
  parameter int WAYS        = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bkvm_pkg::bkvm_cmd_t              cmd,
  output bkvm_pkg::bkvm_stat_t             stat,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bkvm_pkg::BC_W-1:0]        buckets_in_use,
  input  logic [bkvm_pkg::KIND_W-1:0]      kind,
  input  logic [bkvm_pkg::KEY_W-1:0]       key,
  input  logic [bkvm_pkg::KEY_W-1:0]       value_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bkvm_pkg::STATUS_W-1:0]    status,
  output logic [bkvm_pkg::KEY_W-1:0]       value_out,
  output logic [bkvm_pkg::COUNT_W-1:0]     entry_count
);
  import bkvm_pkg::*;

  localparam int ADDR_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LIVE_W = $clog2(MAX_BUCKETS * WAYS + 1);

  // bucket row store
  logic [WAYS-1:0]             mem_valid [MAX_BUCKETS];
  logic [WAYS-1:0][KEY_W-1:0]  mem_key   [MAX_BUCKETS];
  logic [WAYS-1:0][KEY_W-1:0]  mem_val   [MAX_BUCKETS];

  logic [BC_W-1:0]             bc_reg;
  logic [BC_W-1:0]             eff_n;
  logic [BC_W-1:0]             div_n;
  logic [BC_W-1:0]             rem;
  logic [BC_W-1:0]             rem_next;
  logic [BC_W:0]               trial;
  logic [KEY_W-1:0]            key_sh;
  logic [KIND_W-1:0]           kind_r;
  logic [KEY_W-1:0]            key_r;
  logic [KEY_W-1:0]            val_r;
  logic [ADDR_W+BC_W-1:0]      addr_wide;
  logic [ADDR_W-1:0]           addr;
  logic [ADDR_W-1:0]           clr_addr;

  logic [WAYS-1:0]             rd_valid;
  logic [WAYS-1:0][KEY_W-1:0]  rd_key;
  logic [WAYS-1:0][KEY_W-1:0]  rd_val;

  logic                        hit;
  logic [WAY_W-1:0]            hit_idx;
  logic                        free;
  logic [WAY_W-1:0]            free_idx;
  logic                        add_ok;
  logic                        rem_ok;
  logic [WAYS-1:0]             new_valid;
  logic [WAYS-1:0][KEY_W-1:0]  new_key;
  logic [WAYS-1:0][KEY_W-1:0]  new_val;
  logic [STATUS_W-1:0]         res_status;
  logic [STATUS_W-1:0]         res_status_next;
  logic [KEY_W-1:0]            res_value;
  logic [KEY_W-1:0]            res_value_next;
  logic [LIVE_W-1:0]           live;
  logic [LIVE_W+COUNT_W-1:0]   live_wide;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bc_reg <= BC_RESET;
    end else if (cfg_valid) begin
      bc_reg <= buckets_in_use;
    end
  end

  // zero and oversize counts are clamped
  always_comb begin
    eff_n = bc_reg;
    if (bc_reg == '0) begin
      eff_n = BC_W'(1);
    end else if (int'(bc_reg) > MAX_BUCKETS) begin
      eff_n = BC_W'(MAX_BUCKETS);
    end
  end

  // restoring remainder, one key bit per step
  always_comb begin
    trial = {rem, key_sh[KEY_W-1]};
    if (trial >= {1'b0, div_n}) begin
      rem_next = BC_W'(trial - {1'b0, div_n});
    end else begin
      rem_next = trial[BC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      key_r  <= key;
      val_r  <= value_in;
      key_sh <= key;
      div_n  <= eff_n;
      rem    <= '0;
    end else if (cmd.div_step) begin
      rem    <= rem_next;
      key_sh <= {key_sh[KEY_W-2:0], 1'b0};
    end
  end

  assign addr_wide = {ADDR_W'(0), rem};
  assign addr      = addr_wide[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  assign stat.clr_last = (clr_addr == ADDR_W'(MAX_BUCKETS - 1));
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_valid <= mem_valid[addr];
      rd_key   <= mem_key[addr];
      rd_val   <= mem_val[addr];
    end
  end

  // first matching way and lowest free way
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free     = 1'b0;
    free_idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (rd_valid[w]) begin
        if (!hit && rd_key[w] == key_r) begin
          hit     = 1'b1;
          hit_idx = WAY_W'(w);
        end
      end else if (!free) begin
        free     = 1'b1;
        free_idx = WAY_W'(w);
      end
    end
  end

  assign add_ok = (kind_r == KIND_ADD) && !hit && free;
  assign rem_ok = (kind_r == KIND_REMOVE) && hit;

  always_comb begin
    new_valid = rd_valid;
    new_key   = rd_key;
    new_val   = rd_val;
    if (add_ok) begin
      new_valid[free_idx] = 1'b1;
      new_key[free_idx]   = key_r;
      new_val[free_idx]   = val_r;
    end
    if (rem_ok) begin
      new_valid[hit_idx] = 1'b0;
    end
  end

  always_comb begin
    res_value_next = '0;
    unique case (kind_r)
      KIND_ADD: begin
        if (hit) begin
          res_status_next = ST_DUPLICATE;
        end else if (!free) begin
          res_status_next = ST_FULL;
        end else begin
          res_status_next = ST_OK;
        end
      end
      KIND_REMOVE, KIND_GET: begin
        if (hit) begin
          res_status_next = ST_OK;
          res_value_next  = rd_val[hit_idx];
        end else begin
          res_status_next = ST_NOT_FOUND;
        end
      end
      default: res_status_next = ST_NOT_FOUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem_valid[clr_addr] <= '0;
    end else if (cmd.eval && (add_ok || rem_ok)) begin
      mem_valid[addr] <= new_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && add_ok) begin
      mem_key[addr] <= new_key;
      mem_val[addr] <= new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_status <= res_status_next;
      res_value  <= res_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (cmd.eval) begin
      if (add_ok) begin
        live <= live + LIVE_W'(1);
      end else if (rem_ok && live != '0) begin
        live <= live - LIVE_W'(1);
      end
    end
  end

  assign live_wide = {COUNT_W'(0), live};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= res_status;
      value_out   <= res_value;
      entry_count <= live_wide[COUNT_W-1:0];
    end
  end

endmodule

FILE: rtl/bkvm_ctrl.sv
module bkvm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bkvm_pkg::bkvm_stat_t  stat,
  output bkvm_pkg::bkvm_cmd_t   cmd
);
  import bkvm_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_EVAL,
    S_OUT
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.clr_step = (state == S_CLEAR);
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.div_step = (state == S_DIV);
    cmd.rd_en    = (state == S_READ);
    cmd.eval     = (state == S_EVAL);
    cmd.out_load = (state == S_OUT) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      step  <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (stat.clr_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DIV;
            step  <= '0;
          end
        end
        S_DIV: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_EVAL;
        S_EVAL: state <= S_OUT;
        S_OUT: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/bucketed_key_value_map.sv
// channel | signals                            | beat
// --------+------------------------------------+------------------------------
// cfg     | cfg_valid cfg_ready buckets_in_use | new bucket count
// in      | in_valid in_ready                  | kind key value_in
// out     | out_valid out_ready                | status value_out entry_count
//
// each request steps from accept to result through the bit-serial key
// remainder, the bucket row read, the row update and the load of the
// output register. the next request is accepted once the result is
// loaded, even while it waits on out_ready, so a new request is not taken
// before the last one is through; a result that finds the output still full waits.
// after reset a clearing pass over all MAX_BUCKETS rows zeroes the valid marks.
module bucketed_key_value_map #(
  parameter int MAX_BUCKETS = 64,
  parameter int WAYS        = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bkvm_pkg::BC_W-1:0]      buckets_in_use,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bkvm_pkg::KIND_W-1:0]    kind,
  input  logic [bkvm_pkg::KEY_W-1:0]     key,
  input  logic [bkvm_pkg::KEY_W-1:0]     value_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bkvm_pkg::STATUS_W-1:0]  status,
  output logic [bkvm_pkg::KEY_W-1:0]     value_out,
  output logic [bkvm_pkg::COUNT_W-1:0]   entry_count
);
  import bkvm_pkg::*;

  bkvm_cmd_t  cmd;
  bkvm_stat_t stat;

  bkvm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bkvm_datapath #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .WAYS        (WAYS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .buckets_in_use (buckets_in_use),
    .kind           (kind),
    .key            (key),
    .value_in       (value_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .value_out      (value_out),
    .entry_count    (entry_count)
  );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bkvm_pkg::*;

  localparam int MAX_BUCKETS = 64;
  localparam int WAYS        = 4;
  localparam int SLOTS       = MAX_BUCKETS * WAYS;

  // the one request code that the kind enum leaves out
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 45;

  typedef struct {
    status_t            st;
    logic [KEY_W-1:0]   val;
    logic [COUNT_W-1:0] cnt;
  } map_reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [BC_W-1:0]     buckets_in_use = BC_RESET;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   kind = '0;
  logic [KEY_W-1:0]    key = '0;
  logic [KEY_W-1:0]    value_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    value_out;
  logic [COUNT_W-1:0]  entry_count;

  // predicted map contents
  logic               way_valid [SLOTS];
  logic [KEY_W-1:0]   way_key   [SLOTS];
  logic [KEY_W-1:0]   way_value [SLOTS];
  int unsigned        live_count = 0;
  logic [BC_W-1:0]    map_buckets = BC_RESET;

  map_reply_t replies_due [$];
  map_reply_t head_reply;
  int         mismatches = 0;
  int         burst_left = 0;
  logic       offering = 1'b0;
  int         holds_asked = 0;
  int         holds_served = 0;
  int         hold_left = 0;
  int         ready_mode = 0;
  int         mode_left = 0;
  int         cycle_count = 0;

  bucketed_key_value_map #(
    .MAX_BUCKETS(MAX_BUCKETS),
    .WAYS       (WAYS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .buckets_in_use(buckets_in_use),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .key           (key),
    .value_in      (value_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .value_out     (value_out),
    .entry_count   (entry_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      way_valid[i] = 1'b0;
      way_key[i]   = '0;
      way_value[i] = '0;
    end
  end

  function automatic int unsigned live_buckets(input logic [BC_W-1:0] n);
    if (n == 0) return 1;
    if (n > MAX_BUCKETS) return MAX_BUCKETS;
    return 32'(n);
  endfunction

  function automatic map_reply_t map_apply(input logic [KIND_W-1:0] op,
                                           input logic [KEY_W-1:0] k,
                                           input logic [KEY_W-1:0] v);
    map_reply_t  r;
    int unsigned base;
    int          hit;
    int          free_slot;
    r.st = ST_NOT_FOUND;
    r.val = '0;
    base = (k % live_buckets(map_buckets)) * WAYS;
    hit = -1;
    free_slot = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (way_valid[base + w]) begin
        if (hit < 0 && way_key[base + w] == k) hit = base + w;
      end else if (free_slot < 0) begin
        free_slot = base + w;
      end
    end
    case (op)
      KIND_ADD: begin
        if (hit >= 0) r.st = ST_DUPLICATE;
        else if (free_slot < 0) r.st = ST_FULL;
        else begin
          way_valid[free_slot] = 1'b1;
          way_key[free_slot]   = k;
          way_value[free_slot] = v;
          live_count++;
          r.st = ST_OK;
        end
      end
      KIND_REMOVE: begin
        if (hit >= 0) begin
          r.val = way_value[hit];
          way_valid[hit] = 1'b0;
          if (live_count > 0) live_count--;
          r.st = ST_OK;
        end
      end
      KIND_GET: begin
        if (hit >= 0) begin
          r.val = way_value[hit];
          r.st = ST_OK;
        end
      end
      default: ;
    endcase
    r.cnt = live_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic idle_sender();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // sender works in bursts; valid only drops when a gap follows
  task automatic send_request(input logic [KIND_W-1:0] op, input logic [KEY_W-1:0] k,
                              input logic [KEY_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
      if (gap > 0 && offering) begin
        in_valid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    kind <= op;
    key <= k;
    value_in <= v;
    offering = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    replies_due.push_back(map_apply(op, k, v));
  endtask

  task automatic write_buckets_in_use(input logic [BC_W-1:0] n);
    idle_sender();
    wait_drained();
    cfg_valid <= 1'b1;
    buckets_in_use <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    map_buckets = n;
    @(posedge clk);
  endtask

  task automatic test_directed_ops();
    send_request(KIND_GET, 32'h0, 32'h0);
    send_request(KIND_REMOVE, 32'h0, 32'hFFFF_FFFF);
    send_request(KIND_ADD, 32'h0, 32'h0);
    send_request(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(KIND_ADD, 32'h0, 32'h1234_5678);
    send_request(KIND_GET, 32'hFFFF_FFFF, 32'h0);
    send_request(KIND_SPARE, 32'h0, 32'hFFFF_FFFF);
    // four keys in one bucket, then a fifth finds it full
    send_request(KIND_ADD, 32'd5, 32'hA5A5_0005);
    send_request(KIND_ADD, 32'd69, 32'hA5A5_0045);
    send_request(KIND_ADD, 32'd133, 32'hA5A5_0085);
    send_request(KIND_ADD, 32'd197, 32'hA5A5_00C5);
    send_request(KIND_ADD, 32'd261, 32'hA5A5_0105);
    send_request(KIND_GET, 32'd197, 32'h0);
    send_request(KIND_REMOVE, 32'd69, 32'h0);
    send_request(KIND_ADD, 32'd261, 32'h5A5A_0105);
    send_request(KIND_REMOVE, 32'h0, 32'h0);
    send_request(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_request(KIND_GET, 32'h0, 32'h0);
  endtask

  // entries stay in their rows when the bucket count moves under them
  task automatic test_buckets_in_use_change();
    write_buckets_in_use(7'd1);
    send_request(KIND_GET, 32'd5, 32'h0);
    send_request(KIND_ADD, 32'd5, 32'h0BAD_0005);
    write_buckets_in_use(7'd0);
    send_request(KIND_GET, 32'd5, 32'h0);
    send_request(KIND_REMOVE, 32'd5, 32'h0);
    write_buckets_in_use(7'd127);
    send_request(KIND_GET, 32'd5, 32'h0);
    send_request(KIND_GET, 32'd261, 32'h0);
    write_buckets_in_use(7'd64);
  endtask

  task automatic test_output_hold();
    holds_asked++;
    burst_left = 8;
    for (int i = 0; i < 6; i++) send_request(KIND_ADD, $urandom, $urandom);
  endtask

  task automatic test_random_traffic();
    logic [BC_W-1:0]  settings [9];
    logic [KEY_W-1:0] key_pool [12];
    logic [KEY_W-1:0] k;
    logic [KIND_W-1:0] op;
    int unsigned      nb;
    int unsigned      hot;
    int               pick;
    settings = '{7'd1, 7'd2, 7'd3, 7'd7, 7'd64, 7'd0, 7'd127, 7'd13, 7'd40};
    settings[8] = BC_W'($urandom_range(1, 64));
    for (int p = 0; p < 9; p++) begin
      write_buckets_in_use(settings[p]);
      nb = live_buckets(settings[p]);
      hot = $urandom_range(0, nb - 1);
      // half the pool crowds two buckets so rows fill up
      for (int i = 0; i < 12; i++) begin
        k = $urandom;
        if (i < 6) k = k - (k % nb) + ((i % 2) ? hot : (hot + 1) % nb);
        key_pool[i] = k;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) op = KIND_ADD;
        else if (pick < 65) op = KIND_REMOVE;
        else if (pick < 95) op = KIND_GET;
        else op = KIND_SPARE;
        if ($urandom_range(0, 9) == 0) k = $urandom;
        else k = key_pool[$urandom_range(0, 11)];
        send_request(op, k, $urandom);
      end
    end
  endtask

  // receiver: long hold on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (holds_served != holds_asked) begin
      holds_served = holds_asked;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        $error("result beat with nothing expected: status %0d value_out %h entry_count %0d",
               status, value_out, entry_count);
        mismatches++;
      end else begin
        head_reply = replies_due.pop_front();
        if (status !== head_reply.st) begin
          $error("status: expected %0d, got %0d", head_reply.st, status);
          mismatches++;
        end
        if (value_out !== head_reply.val) begin
          $error("value_out: expected %h, got %h", head_reply.val, value_out);
          mismatches++;
        end
        if (entry_count !== head_reply.cnt) begin
          $error("entry_count: expected %0d, got %0d", head_reply.cnt, entry_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_ops();
    test_buckets_in_use_change();
    test_output_hold();
    test_random_traffic();
    idle_sender();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bkvm_pkg.sv
rtl/bkvm_datapath.sv
rtl/bkvm_ctrl.sv
rtl/bucketed_key_value_map.sv
dv/tb_top.sv
